/* design/aes128_block_cipher_ecb_cbc_defines.svh */
// Assertion macros shared by the AES-128 ECB/CBC block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef AES128_BLOCK_CIPHER_ECB_CBC_DEFINES_SVH
`define AES128_BLOCK_CIPHER_ECB_CBC_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define AES_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/aes_pkg.sv */
// Package for the AES-128 block: state encoding, register indexes, S-boxes, round helpers.
// No dependencies.
package aes_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_KEYEXP, ST_ROUND, ST_OUT
  } aes_state_t;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_ENCRYPT  = 3'd4;
  localparam logic [2:0] REG_CHAIN    = 3'd5;

  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage

/* design/aes_round.sv */
// Shared AES round datapath: initial key add or one round, either direction.
// Depends on aes_pkg.
module aes_round (
  input  logic         encrypt,
  input  logic         first,
  input  logic         final_rnd,
  input  logic [127:0] state,
  input  logic [127:0] key_row,
  output logic [127:0] result
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] sh [16];
  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [7:0] ak [16];
  logic [7:0] k [16];
  logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v, b0, b1, b2, b3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[127 - 8*i -: 8];
      k[i] = key_row[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (encrypt) sh[4*c + r] = sbox(s[4*((c + r) & 3) + r]);
        else sh[4*c + r] = inv_sbox(s[4*((c - r + 4) & 3) + r]);
      end
    end
    for (int i = 0; i < 16; i++) sb[i] = sh[i];
    // Encryption mixes before the key; decryption adds the key, then mixes.
    for (int i = 0; i < 16; i++) ak[i] = encrypt ? sb[i] : (sb[i] ^ k[i]);
    for (int c = 0; c < 4; c++) begin
      a0 = ak[4*c]; a1 = ak[4*c+1]; a2 = ak[4*c+2]; a3 = ak[4*c+3];
      if (!encrypt) begin
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        b0 = a0 ^ u; b1 = a1 ^ v; b2 = a2 ^ u; b3 = a3 ^ v;
      end else begin
        u = '0; v = '0;
        b0 = a0; b1 = a1; b2 = a2; b3 = a3;
      end
      x0 = xtime(b0 ^ b1); x1 = xtime(b1 ^ b2); x2 = xtime(b2 ^ b3); x3 = xtime(b3 ^ b0);
      u = b0 ^ b1 ^ b2 ^ b3;
      mx[4*c]   = b0 ^ u ^ x0;
      mx[4*c+1] = b1 ^ u ^ x1;
      mx[4*c+2] = b2 ^ u ^ x2;
      mx[4*c+3] = b3 ^ u ^ x3;
    end
    for (int i = 0; i < 16; i++) begin
      if (first) ak[i] = s[i] ^ k[i];
      else if (final_rnd) ak[i] = sb[i] ^ k[i];
      else if (encrypt) ak[i] = mx[i] ^ k[i];
      else ak[i] = mx[i];
      result[127 - 8*i -: 8] = ak[i];
    end
  end
endmodule

/* design/aes128_block_cipher_ecb_cbc.sv */
// AES-128 ECB/CBC block cipher, one shared round unit stepped by a small sequencer.
// The result is presented after 11 round steps, including the initial key addition, and is
// held until taken; a new request is accepted only after the previous result is taken. After
// a key write the first request waits until key expansion, one word per cycle, has ended
// and the sequencer has returned to idle, where the request is taken.
// Reset (rst, synchronous) clears control state, loads a zero IV into the chaining
// register and selects encryption in ECB mode. Round keys are undefined until expanded.
`include "aes128_block_cipher_ecb_cbc_defines.svh"
module aes128_block_cipher_ecb_cbc #(
  parameter int NUM_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic        out_last
);
  import aes_pkg::*;

  localparam int KeyWords = 4 * (NUM_ROUNDS + 1);
  localparam int KwBits = $clog2(KeyWords);
  localparam int RndBits = $clog2(NUM_ROUNDS + 1);

  // Configuration registers. The chaining register reloads from the IV on an IV
  // write and after every request marked last, in either mode.
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic encrypt_select, chain_select, key_pending;
  logic [127:0] chain;

  // Round keys are held as full 128-bit rows, one row per round step, so the
  // round unit reads one row a cycle. Expansion writes one word per cycle.
  logic [127:0] rk_mem [NUM_ROUNDS + 1];
  logic [31:0] w [4];
  logic [KwBits-1:0] kw;

  aes_state_t state, state_next;
  logic [RndBits-1:0] rnd;
  logic [RndBits-1:0] rnd_n;
  logic enc_sel;
  logic [127:0] data, in_blk, res, rkey;
  logic [127:0] cin;
  logic enc_q, cbc_q, last_q;
  logic [31:0] tw, nw;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // After expansion the sequencer returns to idle, where the waiting request is taken.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = key_pending ? ST_KEYEXP : ST_ROUND;
      ST_KEYEXP: if (kw == KwBits'(KeyWords - 1)) state_next = ST_IDLE;
      ST_ROUND: if (rnd == RndBits'(NUM_ROUNDS)) state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE) || key_pending;
  assign out_valid = (state == ST_OUT);

  // Key schedule word generator.
  always_comb begin
    tw = w[3];
    if (kw[1:0] == 2'd0)
      tw = {sbox(w[3][23:16]) ^ rcon(RndBits'(kw >> 2)), sbox(w[3][15:8]),
            sbox(w[3][7:0]), sbox(w[3][31:24])};
    nw = w[0] ^ tw;
  end

  // Round key for the next step: decryption walks the rows backwards. On the
  // accepting edge the direction comes straight from the register.
  assign rnd_n = (state == ST_ROUND && rnd != RndBits'(NUM_ROUNDS)) ?
                 rnd + RndBits'(1) : '0;
  assign enc_sel = (state == ST_IDLE) ? encrypt_select : enc_q;

  always_ff @(posedge clk) begin
    rkey <= rk_mem[enc_sel ? rnd_n : RndBits'(NUM_ROUNDS) - rnd_n];
  end

  aes_round u_round (
    .encrypt(enc_q), .first(rnd == '0), .final_rnd(rnd == RndBits'(NUM_ROUNDS)),
    .state(data), .key_row(rkey), .result(res)
  );

  assign in_blk = {block_high, block_low};

  always_ff @(posedge clk) begin
    if (state == ST_KEYEXP) begin
      w <= '{w[1], w[2], w[3], nw};
      kw <= kw + KwBits'(1);
      rk_mem[kw[KwBits-1:2]][127 - 32*kw[1:0] -: 32] <= nw;
    end else if (state == ST_IDLE) begin
      w <= '{key_high[63:32], key_high[31:0], key_low[63:32], key_low[31:0]};
      kw <= KwBits'(4);
      rk_mem[0] <= {key_high, key_low};
    end
    if (state == ST_IDLE && in_valid && !key_pending) begin
      enc_q <= encrypt_select;
      cbc_q <= chain_select;
      last_q <= last_block;
      data <= (chain_select && encrypt_select) ? (in_blk ^ chain) : in_blk;
      rnd <= '0;
    end else if (state == ST_ROUND) begin
      data <= res;
      if (rnd != RndBits'(NUM_ROUNDS)) rnd <= rnd + RndBits'(1);
    end
  end

  // Registers and chaining.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      encrypt_select <= 1'b1; chain_select <= 1'b0; key_pending <= 1'b0;
      chain <= '0;
    end else begin
      if (state == ST_KEYEXP && kw == KwBits'(KeyWords - 1)) key_pending <= 1'b0;
      if (state == ST_OUT && !out_stall) begin
        if (last_q) chain <= {iv_high, iv_low};
        else if (cbc_q) chain <= enc_q ? data : cin;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: begin key_high <= cfg_data; key_pending <= 1'b1; end
          REG_KEY_LOW:  begin key_low <= cfg_data; key_pending <= 1'b1; end
          REG_IV_HIGH:  begin iv_high <= cfg_data; chain <= {cfg_data, iv_low}; end
          REG_IV_LOW:   begin iv_low <= cfg_data; chain <= {iv_high, cfg_data}; end
          REG_ENCRYPT:  encrypt_select <= cfg_data[0];
          REG_CHAIN:    chain_select <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Ciphertext input kept for the decryption chain.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && !key_pending) cin <= in_blk;
  end

  // The CBC decrypt XOR is applied at the output against the chain value, which
  // moves on only once the result is taken or on an IV write.
  logic [127:0] out_blk;
  assign out_blk = (cbc_q && !enc_q) ? (data ^ chain) : data;
  assign out_high = out_blk[127:64];
  assign out_low = out_blk[63:0];
  assign out_last = last_q;

  `AES_ASSERT_IMP(a_busy_stall, clk, rst, state != ST_IDLE, in_stall, "accepted while busy")
  `AES_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "output dropped")
  `AES_ASSERT_IMP(a_exp_range, clk, rst, state == ST_KEYEXP, kw >= KwBits'(4), "bad key word")
endmodule
